### src/ecal_pkg.sv
package ecal_pkg;

	// field widths
	localparam int unsigned EpochW = 32;
	localparam int unsigned YearW  = 12;
	localparam int unsigned MonW   = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned HourW  = 5;
	localparam int unsigned MinW   = 6;
	localparam int unsigned SecW   = 6;

	// width of the shared compare-subtract unit and of the day count
	localparam int unsigned UnitW  = 16;

	// reciprocals for the divisions: x / 60 = (x * Recip60) >> 37,
	// x / 24 = (x * Recip24) >> 36, exact for every 32-bit x
	localparam logic [EpochW-1:0] Recip60 = 32'h8888_8889;
	localparam logic [EpochW-1:0] Recip24 = 32'hAAAA_AAAB;

	// calendar constants
	localparam logic [YearW-1:0] BaseYear  = 12'd1970;
	localparam logic [YearW-1:0] Year2100  = 12'd2100;
	// four-year blocks start at 1970, 1974, ...; the block at 2098 holds 2100
	localparam logic [YearW-1:0] QuadLimit = 12'd2098;
	localparam logic [UnitW-1:0] QuadDays  = 16'd1461;
	localparam logic [UnitW-1:0] YearDays  = 16'd365;
	localparam logic [UnitW-1:0] LeapDays  = 16'd366;

	// status from the sequencer to the top level
	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

	// one converted date and time
	typedef struct packed {
		logic [YearW-1:0] year;
		logic [MonW-1:0]  month;
		logic [DayW-1:0]  day;
		logic [HourW-1:0] hour;
		logic [MinW-1:0]  minute;
		logic [SecW-1:0]  second;
	} cal_t;

	// gregorian leap rule over 1970..2106: 2100 is the only century that is not leap
	function automatic logic is_leap(input logic [YearW-1:0] y);
		return (y[1:0] == 2'b00) && (y != Year2100);
	endfunction

	// days in a month, february lengthened in leap years
	function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] m, input logic leap);
		logic [DayW-1:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### src/ecal_sub.sv
module ecal_sub (
	input  logic [ecal_pkg::UnitW-1:0] a,
	input  logic [ecal_pkg::UnitW-1:0] b,
	output logic                       ge,
	output logic [ecal_pkg::UnitW-1:0] diff
);

	logic borrow;

	// single subtractor, borrow out gives the compare
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

### src/ecal_seq.sv
module ecal_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ecal_pkg::EpochW-1:0] epoch_seconds,
	input  logic                        take,
	output ecal_pkg::seq_stat_t         stat,
	output ecal_pkg::cal_t              cal
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_QUAD  = 6'b000100,
		ST_YEAR  = 6'b001000,
		ST_MONTH = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		DIV_SEC  = 2'd0,
		DIV_MIN  = 2'd1,
		DIV_HOUR = 2'd2
	} dsel_t;

	state_t                          state_q;
	dsel_t                           dsel_q;
	logic                            rem_phase_q;
	logic [ecal_pkg::EpochW-1:0]     num_q;
	logic [ecal_pkg::EpochW-1:0]     quo_q;
	logic [ecal_pkg::UnitW-1:0]      days_q;
	logic [ecal_pkg::YearW-1:0]      year_q;
	logic [ecal_pkg::MonW-1:0]       mon_q;
	logic [ecal_pkg::DayW-1:0]       mday_q;
	logic [ecal_pkg::HourW-1:0]      hour_q;
	logic [ecal_pkg::MinW-1:0]       min_q;
	logic [ecal_pkg::SecW-1:0]       sec_q;

	logic [ecal_pkg::UnitW-1:0]      unit_a;
	logic [ecal_pkg::UnitW-1:0]      unit_b;
	logic [ecal_pkg::UnitW-1:0]      unit_diff;
	logic                            unit_ge;
	logic                            leap;
	logic                            quad_ok;
	logic [ecal_pkg::EpochW-1:0]     mul_b;
	logic [2*ecal_pkg::EpochW-1:0]   mul_prod;
	logic [ecal_pkg::EpochW-1:0]     quo_next;
	logic [ecal_pkg::SecW-1:0]       rem60;
	logic [ecal_pkg::HourW-1:0]      rem24;

	assign leap = ecal_pkg::is_leap(year_q);

	// operand select for the shared compare-subtract unit
	always_comb begin
		unit_a = days_q;
		unit_b = ecal_pkg::QuadDays;
		case (state_q)
			ST_YEAR: begin
				unit_b = leap ? ecal_pkg::LeapDays : ecal_pkg::YearDays;
			end
			ST_MONTH: begin
				unit_b = {{(ecal_pkg::UnitW-ecal_pkg::DayW){1'b0}},
					ecal_pkg::month_days(mon_q, leap)};
			end
			default: begin
				unit_b = ecal_pkg::QuadDays;
			end
		endcase
	end

	ecal_sub u_sub (
		.a    (unit_a),
		.b    (unit_b),
		.ge   (unit_ge),
		.diff (unit_diff)
	);

	// shared 32x32 reciprocal multiplier for the three divisions
	assign mul_b    = (dsel_q == DIV_HOUR) ? ecal_pkg::Recip24 : ecal_pkg::Recip60;
	assign mul_prod = {{ecal_pkg::EpochW{1'b0}}, num_q} * {{ecal_pkg::EpochW{1'b0}}, mul_b};
	assign quo_next = (dsel_q == DIV_HOUR) ? {4'd0, mul_prod[63:36]} : {5'd0, mul_prod[63:37]};

	// remainders from the low bits only: -60 is 4 mod 64, -24 is 8 mod 32
	assign rem60 = num_q[ecal_pkg::SecW-1:0] + {quo_q[3:0], 2'b00};
	assign rem24 = num_q[ecal_pkg::HourW-1:0] + {quo_q[1:0], 3'b000};

	// a four-year block may be taken only while it holds no year 2100
	assign quad_ok = unit_ge && (year_q < ecal_pkg::QuadLimit);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dsel_q      <= DIV_SEC;
			rem_phase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q     <= ST_DIV;
						dsel_q      <= DIV_SEC;
						rem_phase_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (!rem_phase_q) begin
						rem_phase_q <= 1'b1;
					end else begin
						rem_phase_q <= 1'b0;
						case (dsel_q)
							DIV_SEC: begin
								dsel_q <= DIV_MIN;
							end
							DIV_MIN: begin
								dsel_q <= DIV_HOUR;
							end
							default: begin
								state_q <= ST_QUAD;
							end
						endcase
					end
				end
				ST_QUAD: begin
					if (!quad_ok) begin
						state_q <= ST_YEAR;
					end
				end
				ST_YEAR: begin
					if (!unit_ge) begin
						state_q <= ST_MONTH;
					end
				end
				ST_MONTH: begin
					if (!unit_ge) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					num_q <= epoch_seconds;
				end
			end
			ST_DIV: begin
				if (!rem_phase_q) begin
					quo_q <= quo_next;
				end else begin
					case (dsel_q)
						DIV_SEC: begin
							sec_q <= rem60;
							num_q <= quo_q;
						end
						DIV_MIN: begin
							min_q <= rem60;
							num_q <= quo_q;
						end
						default: begin
							hour_q <= rem24;
							days_q <= quo_q[ecal_pkg::UnitW-1:0];
							year_q <= ecal_pkg::BaseYear;
						end
					endcase
				end
			end
			ST_QUAD: begin
				if (quad_ok) begin
					days_q <= unit_diff;
					year_q <= year_q + 12'd4;
				end
			end
			ST_YEAR: begin
				if (unit_ge) begin
					days_q <= unit_diff;
					year_q <= year_q + 12'd1;
				end else begin
					mon_q <= 4'd1;
				end
			end
			ST_MONTH: begin
				if (unit_ge) begin
					days_q <= unit_diff;
					mon_q  <= mon_q + 4'd1;
				end else begin
					mday_q <= days_q[ecal_pkg::DayW-1:0] + 5'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.busy  = (state_q != ST_IDLE);
	assign stat.done  = (state_q == ST_DONE);

	assign cal.year   = year_q;
	assign cal.month  = mon_q;
	assign cal.day    = mday_q;
	assign cal.hour   = hour_q;
	assign cal.minute = min_q;
	assign cal.second = sec_q;

endmodule

### src/epoch_to_calendar.sv
// Unix time to UTC calendar date and time of day.
//
// Input channel: in_valid / in_stall with epoch_seconds, the unsigned count of
// seconds since 1970-01-01 00:00:00 UTC. A request is taken at a rising edge
// with in_valid high and in_stall low. Output channel: out_valid / out_stall
// with year, month, day, hour, minute and second, one result per request.
//
// One request is converted at a time. A shared 32x32 reciprocal multiplier
// splits off second, minute and hour, with a quotient step and a remainder
// step per divisor; a shared compare-subtract unit then takes up to 32
// four-year steps, up to 8 single-year steps and up to 11 month steps, each
// walk ending with one failing compare. in_stall is high from acceptance
// until the result has moved to the output register, so no new request is
// taken while one is being converted.
//
// The result sits in an output register, so a new request is taken as soon
// as the result has moved there, even while out_stall holds it. If out_stall
// keeps the output register full, the next finished result waits inside the
// block and in_stall stays high.
// Reset clears the sequencer and the output valid; no request is in flight.
module epoch_to_calendar (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ecal_pkg::EpochW-1:0] epoch_seconds,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ecal_pkg::YearW-1:0]  year,
	output logic [ecal_pkg::MonW-1:0]   month,
	output logic [ecal_pkg::DayW-1:0]   day,
	output logic [ecal_pkg::HourW-1:0]  hour,
	output logic [ecal_pkg::MinW-1:0]   minute,
	output logic [ecal_pkg::SecW-1:0]   second
);

	ecal_pkg::seq_stat_t stat;
	ecal_pkg::cal_t      cal;
	ecal_pkg::cal_t      cal_q;
	logic                out_valid_q;
	logic                start;
	logic                take;

	// request handshake
	assign in_stall = stat.busy;
	assign start    = in_valid && !in_stall;

	// move a finished result when the output register is free
	assign take = stat.done && (!out_valid_q || !out_stall);

	ecal_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.epoch_seconds (epoch_seconds),
		.take          (take),
		.stat          (stat),
		.cal           (cal)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take) begin
			cal_q <= cal;
		end
	end

	assign out_valid = out_valid_q;
	assign year      = cal_q.year;
	assign month     = cal_q.month;
	assign day       = cal_q.day;
	assign hour      = cal_q.hour;
	assign minute    = cal_q.minute;
	assign second    = cal_q.second;

`ifndef SYNTH
	// a taken request keeps the block busy on the next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block not busy after taking a request");

	// a finished result moves into an empty output register
	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && !out_valid) |=> out_valid)
		else $error("finished result not loaded into empty output register");

	// date fields stay in calendar range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1 &&
			month <= 4'd12 && day != 5'd0))
		else $error("date field out of range");

	// time of day fields stay in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
		else $error("time field out of range");
`endif

endmodule

### dv/tb_epoch_to_calendar.sv
module tb_epoch_to_calendar;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SecsPerDay  = 86400;
	localparam int unsigned IdleLimit   = 2000;
	localparam int unsigned DrainCycles = 150;
	localparam int unsigned RandomItems = 400;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [ecal_pkg::EpochW-1:0]    epoch_seconds;
	logic                           out_valid;
	logic                           out_stall;
	logic [ecal_pkg::YearW-1:0]     year;
	logic [ecal_pkg::MonW-1:0]      month;
	logic [ecal_pkg::DayW-1:0]      day;
	logic [ecal_pkg::HourW-1:0]     hour;
	logic [ecal_pkg::MinW-1:0]      minute;
	logic [ecal_pkg::SecW-1:0]      second;

	// dates still owed by the block, oldest first
	ecal_pkg::cal_t pending_dates[$];
	int unsigned    error_count = 0;
	bit             no_idle = 1'b0;
	int unsigned    quiet_cycles = 0;

	epoch_to_calendar uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.epoch_seconds (epoch_seconds),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// full gregorian rule, centuries included
	function automatic bit leap_year(input int unsigned yr);
		return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
	endfunction

	function automatic int unsigned month_length(input int unsigned mo, input bit leap);
		int unsigned len;
		case (mo)
			2: len = leap ? 29 : 28;
			4, 6, 9, 11: len = 30;
			default: len = 31;
		endcase
		return len;
	endfunction

	// expected calendar date and time of day for one epoch count
	function automatic ecal_pkg::cal_t calendar_of(input logic [ecal_pkg::EpochW-1:0] t);
		ecal_pkg::cal_t r;
		int unsigned    secs;
		int unsigned    days;
		int unsigned    yr;
		int unsigned    mo;
		int unsigned    span;
		secs = t;
		r.second = ecal_pkg::SecW'(secs % 60);
		r.minute = ecal_pkg::MinW'((secs / 60) % 60);
		r.hour = ecal_pkg::HourW'((secs / 3600) % 24);
		days = secs / SecsPerDay;
		// strip whole years
		yr = 1970;
		span = leap_year(yr) ? 366 : 365;
		while (days >= span) begin
			days -= span;
			yr++;
			span = leap_year(yr) ? 366 : 365;
		end
		// strip whole months of that year
		mo = 1;
		span = month_length(mo, leap_year(yr));
		while (days >= span) begin
			days -= span;
			mo++;
			span = month_length(mo, leap_year(yr));
		end
		r.year = ecal_pkg::YearW'(yr);
		r.month = ecal_pkg::MonW'(mo);
		r.day = ecal_pkg::DayW'(days + 1);
		return r;
	endfunction

	// seconds at the first instant of a given month
	function automatic longint month_start(input int unsigned yr, input int unsigned mo);
		longint days;
		days = 0;
		for (int unsigned y = 1970; y < yr; y++)
			days += leap_year(y) ? 366 : 365;
		for (int unsigned m = 1; m < mo; m++)
			days += month_length(m, leap_year(yr));
		return days * SecsPerDay;
	endfunction

	function automatic logic [ecal_pkg::EpochW-1:0] clamp_epoch(input longint t);
		if (t < 0)
			return '0;
		if (t > longint'(32'hFFFF_FFFF))
			return '1;
		return ecal_pkg::EpochW'(t);
	endfunction

	// a few seconds either side of a month start, year starts included
	function automatic logic [ecal_pkg::EpochW-1:0] near_month_edge();
		int unsigned yr;
		int unsigned mo;
		longint      t;
		yr = $urandom_range(2106, 1970);
		mo = (yr == 2106) ? $urandom_range(2, 1) : $urandom_range(12, 1);
		t = month_start(yr, mo) + longint'($urandom_range(6, 0)) - 3;
		return clamp_epoch(t);
	endfunction

	// a few seconds either side of midnight on a random day
	function automatic logic [ecal_pkg::EpochW-1:0] near_midnight();
		longint t;
		t = longint'($urandom / SecsPerDay) * SecsPerDay + longint'($urandom_range(6, 0)) - 3;
		return clamp_epoch(t);
	endfunction

	// drive one request and wait for it to be taken
	task automatic send_request(input logic [ecal_pkg::EpochW-1:0] t);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(5, 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_dates.push_back(calendar_of(t));
	endtask

	// hold off until every owed result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	// result checker with random output stall
	initial begin : result_check
		int unsigned    stall_left;
		ecal_pkg::cal_t want;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_dates.size() == 0) begin
					$error("result with no request outstanding");
					error_count++;
				end else begin
					want = pending_dates.pop_front();
					if (year !== want.year) begin
						$error("year: expected %0d, got %0d", want.year, year);
						error_count++;
					end
					if (month !== want.month) begin
						$error("month: expected %0d, got %0d", want.month, month);
						error_count++;
					end
					if (day !== want.day) begin
						$error("day: expected %0d, got %0d", want.day, day);
						error_count++;
					end
					if (hour !== want.hour) begin
						$error("hour: expected %0d, got %0d", want.hour, hour);
						error_count++;
					end
					if (minute !== want.minute) begin
						$error("minute: expected %0d, got %0d", want.minute, minute);
						error_count++;
					end
					if (second !== want.second) begin
						$error("second: expected %0d, got %0d", want.second, second);
						error_count++;
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(5, 0);
			end else if (out_valid && stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	// watchdog on cycles where neither side moves a request
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// zero, all ones, field rollovers and bit patterns
	task automatic test_range_extremes();
		send_request(32'd0);
		send_request(32'd1);
		send_request(32'd59);
		send_request(32'd60);
		send_request(32'd3599);
		send_request(32'd3600);
		send_request(32'd86399);
		send_request(32'd86400);
		send_request(32'h7FFF_FFFF);
		send_request(32'h8000_0000);
		send_request(32'hAAAA_AAAA);
		send_request(32'h5555_5555);
		send_request(32'hFFFF_FFFE);
		send_request(32'hFFFF_FFFF);
	endtask

	// leap days: ordinary leap year, 2000 divisible by 400, 2100 not leap
	task automatic test_leap_rules();
		no_idle = 1'b1;
		send_request(32'd31535999);
		send_request(32'd31536000);
		send_request(32'd68169599);
		send_request(32'd68169600);
		send_request(32'd946684799);
		send_request(32'd946684800);
		send_request(32'd951782400);
		send_request(32'd951868800);
		send_request(32'd4107542399);
		send_request(32'd4107542400);
		no_idle = 1'b0;
	endtask

	// random times, weighted toward month, year and day edges
	task automatic test_random_times();
		int unsigned pick;
		for (int unsigned n = 0; n < RandomItems; n++) begin
			// one stretch with no gaps or stalls on either side
			no_idle = (n >= 100 && n < 160);
			// sender holds off once until the block has emptied
			if (n == 250)
				wait_drained();
			pick = $urandom_range(9, 0);
			if (pick < 5)
				send_request($urandom);
			else if (pick < 8)
				send_request(near_month_edge());
			else
				send_request(near_midnight());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		epoch_seconds <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_range_extremes();
		wait_drained();
		test_leap_rules();
		wait_drained();
		test_random_times();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
